FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, muted in reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock, muted in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: design/scrb_pkg.sv
// Shared types, codes and the sample scaling function for the capture/review buffer.
// No dependencies.
package scrb_pkg;

   // request codes
   typedef enum logic [1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_MODE   = 2'd1,
      REQ_PREV   = 2'd2,
      REQ_NEXT   = 2'd3
   } req_code_type;

   typedef enum logic {
      ST_IDLE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [9:0] sample;
   } req_data_type;

   typedef struct packed {
      logic       reviewing;
      logic       stored;
      logic       shown;
      logic [8:0] entry_index;
      logic [7:0] entry_value;
      logic       full_res;
   } rsp_data_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic respond;
   } cmd_type;

   // floor(s * 255 / 1023): 255*s by shift and subtract, then divide by
   // 1023 as (p + (p >> 10) + 1) >> 10, exact for p below 1023*1024
   function automatic logic [7:0] scale_sample(input logic [9:0] s);
      logic [17:0] p;
      logic [17:0] t;
      p = ({8'b0, s} << 8) - {8'b0, s};
      t = p + {10'b0, p[17:10]} + 18'd1;
      return t[17:10];
   endfunction

endpackage

FILE: design/scrb_ctrl.sv
// Controller for the capture/review buffer: accept, then present one result.
// Depends on scrb_pkg.
module scrb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output scrb_pkg::cmd_type cmd
);
   import scrb_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.respond = 1'b0;
      busy        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            // drive the strobe for one cycle, hold off new transactions
            busy        = 1'b1;
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: design/scrb_dp.sv
// Datapath for the capture/review buffer: byte store, fill count, cursor, result.
// Depends on scrb_pkg.
module scrb_dp #(
   parameter int DEPTH = 512
) (
   input  logic                   clock,
   input  logic                   reset,
   input  scrb_pkg::cmd_type      cmd,
   input  scrb_pkg::req_data_type req_data,
   output scrb_pkg::rsp_data_type rsp_data
);
   import scrb_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   logic [7:0] mem [DEPTH];

   logic [CNT_W-1:0] wc_ff, wc_in;
   logic             review_ff, review_in;
   logic [IDX_W-1:0] cursor_ff, cursor_in;
   logic [IDX_W-1:0] last_ff, last_in;

   logic             wr_en;
   logic [7:0]       wr_byte;
   logic [IDX_W-1:0] rd_addr;
   logic             stored_in, shown_in;
   logic [IDX_W-1:0] idx_in;
   logic [IDX_W-1:0] wc_idx, wc_last;

   logic             stored_ff, shown_ff, full_ff, rd_ok_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [7:0]       wr_byte_ff, rd_data_ff;
   logic [IDX_W+8:0] idx_wide;

   assign wc_idx  = wc_ff[IDX_W-1:0];
   assign wc_last = (wc_ff == '0) ? '0 : IDX_W'(wc_ff - CNT_W'(1));
   assign wr_byte = scale_sample(req_data.sample);

   always_comb begin
      wc_in     = wc_ff;
      review_in = review_ff;
      cursor_in = cursor_ff;
      last_in   = last_ff;
      wr_en     = 1'b0;
      rd_addr   = cursor_ff;
      stored_in = 1'b0;
      shown_in  = 1'b0;
      idx_in    = '0;
      case (req_data.req_type)
         REQ_SAMPLE: begin
            if (!review_ff && wc_ff != DEPTH_C) begin
               wr_en     = cmd.load;
               stored_in = 1'b1;
               idx_in    = wc_idx;
               wc_in     = wc_ff + CNT_W'(1);
            end
         end
         REQ_MODE: begin
            if (review_ff) begin
               // drop the fill count: unwritten entries read as zero
               wc_in     = '0;
               review_in = 1'b0;
               cursor_in = '0;
            end else begin
               last_in   = wc_last;
               cursor_in = wc_last;
               review_in = 1'b1;
               shown_in  = 1'b1;
               idx_in    = wc_last;
               rd_addr   = wc_last;
            end
         end
         REQ_PREV: begin
            if (review_ff && cursor_ff != '0) begin
               cursor_in = cursor_ff - IDX_W'(1);
               shown_in  = 1'b1;
               idx_in    = cursor_in;
               rd_addr   = cursor_in;
            end
         end
         REQ_NEXT: begin
            if (review_ff && cursor_ff < last_ff) begin
               cursor_in = cursor_ff + IDX_W'(1);
               shown_in  = 1'b1;
               idx_in    = cursor_in;
               rd_addr   = cursor_in;
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wc_ff     <= '0;
         review_ff <= 1'b0;
         cursor_ff <= '0;
         last_ff   <= '0;
      end else if (cmd.load) begin
         wc_ff     <= wc_in;
         review_ff <= review_in;
         cursor_ff <= cursor_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wc_idx] <= wr_byte;
      end
      if (cmd.load) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         stored_ff  <= stored_in;
         shown_ff   <= shown_in;
         idx_ff     <= idx_in;
         wr_byte_ff <= wr_byte;
         rd_ok_ff   <= CNT_W'(rd_addr) < wc_ff;
         full_ff    <= wc_in == DEPTH_C;
      end
   end

   assign idx_wide = {9'b0, idx_ff};

   always_comb begin
      rsp_data.reviewing   = review_ff;
      rsp_data.stored      = stored_ff;
      rsp_data.shown       = shown_ff;
      rsp_data.entry_index = (stored_ff || shown_ff) ? idx_wide[8:0] : 9'd0;
      rsp_data.full_res    = full_ff;
      if (stored_ff) begin
         rsp_data.entry_value = wr_byte_ff;
      end else if (shown_ff && rd_ok_ff) begin
         rsp_data.entry_value = rd_data_ff;
      end else begin
         rsp_data.entry_value = 8'd0;
      end
   end

endmodule

FILE: design/sample_capture_review_buffer.sv
// Sample capture and review buffer, top level.
// The result strobe is raised in the cycle after the accepting one.
// No overlap: each transaction is accepted, then its result cycle holds busy.
// Leaving review needs no clearing pass: a fill count marks the valid entries.
// Reset (synchronous, active high) returns to capture mode with an empty store.
// Results cannot be stalled; rsp_data holds each until the next accept.
module sample_capture_review_buffer #(
   parameter int DEPTH = 512
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  scrb_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   output scrb_pkg::rsp_data_type rsp_data
);
   import scrb_pkg::*;

   cmd_type cmd;

   // Controller: accept a transaction when idle, then raise the result strobe
   // for exactly one cycle while holding busy.
   scrb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Datapath: the byte store is written at the fill count while capturing;
   // review reads are registered on the accepting edge and shown next cycle.
   // Entries at or beyond the fill count read as zero, which stands in for
   // the cleared store after reset and after leaving review.
   scrb_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   assign rsp_valid = cmd.respond;

endmodule

FILE: design/scrb_checker.sv
// Port-level checks for the capture/review buffer, and the bind that attaches them.
// Depends on scrb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module scrb_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input scrb_pkg::rsp_data_type rsp_data
);
   import scrb_pkg::*;

   // every accepted transaction yields its result in the next cycle
   `ASSERT_NEXT(a_result_follows, clock, reset, start && !busy, rsp_valid)
   // the result cycle blocks new transactions
   `ASSERT_IMPLIES(a_busy_on_result, clock, reset, rsp_valid, busy)
   // a write only happens in capture mode
   `ASSERT_IMPLIES(a_store_capture, clock, reset, rsp_valid && rsp_data.stored,
                   !rsp_data.reviewing && !rsp_data.shown)
   // a display only happens in review mode
   `ASSERT_IMPLIES(a_show_review, clock, reset, rsp_valid && rsp_data.shown,
                   rsp_data.reviewing)

endmodule

bind sample_capture_review_buffer scrb_checker u_scrb_checker (.*);
